// ===== src/shbb_pkg.sv =====
`timescale 1ns / 1ps

package shbb_pkg;

   // Table geometry; the bucket and bloom word counts are powers of two.
   localparam int NUM_BUCKETS     = 16;
   localparam int BLOOM_WORDS     = 4;
   localparam int BLOOM_WORD_BITS = 32;

   localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
   localparam int BLOOM_IDX_W = $clog2(BLOOM_WORDS);
   localparam int BIT_IDX_W   = $clog2(BLOOM_WORD_BITS);

   localparam logic [31:0] HASH_SEED       = 32'd5381;
   localparam logic [3:0]  SYM_TYPE_FILE   = 4'd4;
   localparam logic [3:0]  SYM_BIND_LOCAL  = 4'd0;
   localparam logic [7:0]  NAME_TERMINATOR = 8'd0;
   localparam logic [15:0] SECTION_UNDEF   = 16'd0;
   localparam logic [4:0]  BLOOM_SHIFT_RST = 5'd5;

   // One name byte plus the symbol attributes used at the terminator.
   typedef struct packed {
      logic [7:0]  name_byte;
      logic [7:0]  sym_info;
      logic [15:0] section_index;
   } req_payload_type;

   // One completed symbol.
   typedef struct packed {
      logic [31:0] symbol_hash;
      logic [3:0]  bucket_number;
      logic        is_local;
      logic [1:0]  bloom_word_index;
      logic [31:0] bloom_word_value;
   } rsp_payload_type;

endpackage

// ===== src/symbol_hash_bloom_builder.sv =====
`timescale 1ns / 1ps

// Symbol hash and bloom filter builder.
// The req channel carries one symbol-name byte per item, with the symbol's
// info byte and section index; those two are only looked at when the byte is
// zero, which ends the name. Non-zero bytes fold into a running djb2 hash
// (h*33 + byte) and produce no result. A zero byte produces one rsp item in
// the cycle after it is accepted: the hash, its bucket, the local flag, and the
// index and new value of the bloom word that received the symbol's two bits.
// The running hash then restarts at 5381.
// Throughput is one item per cycle unless rsp stalls; the hash update is a
// single shift-add and the bloom update a single read-modify-write of a word
// register. The csr channel writes the 5-bit bloom shift and is always ready.
// Reset clears the bloom words and the result valid flag, and loads the seed
// and a shift of 5. While rsp is stalled with a result pending, req_ready
// stays low; it rises in the cycle the pending result is taken.
module symbol_hash_bloom_builder
   import shbb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [4:0]      csr_data
);

   logic [31:0]                bloom_ff [BLOOM_WORDS];
   logic [31:0]                hash_ff;
   logic [31:0]                hash_in;
   logic [4:0]                 shift_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   rsp_payload_type            rsp_ff;
   rsp_payload_type            rsp_in;
   logic                       accept;
   logic                       terminator;
   logic [31:0]                hash_second;
   logic [31:0]                bit_mask;
   logic [BLOOM_IDX_W-1:0]     word_idx;
   logic [31:0]                word_new;
   logic                       local_sym;

   assign accept     = req_valid && req_ready;
   assign terminator = (req_payload.name_byte == NAME_TERMINATOR);
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Bloom word selection and the two bits that the symbol sets.
   assign hash_second = hash_ff >> shift_ff;
   assign word_idx    = hash_ff[BIT_IDX_W +: BLOOM_IDX_W];
   assign bit_mask    = (32'd1 << hash_ff[BIT_IDX_W-1:0]) |
                        (32'd1 << hash_second[BIT_IDX_W-1:0]);
   assign word_new    = bloom_ff[word_idx] | bit_mask;

   // A symbol is local if it is a file entry, has local binding or no section.
   assign local_sym = (req_payload.sym_info[3:0] == SYM_TYPE_FILE) ||
                      (req_payload.sym_info[7:4] == SYM_BIND_LOCAL) ||
                      (req_payload.section_index == SECTION_UNDEF);

   // Running hash: shift-add by 33, back to the seed after a terminator.
   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         if (terminator) begin
            hash_in = HASH_SEED;
         end else begin
            hash_in = (hash_ff << 5) + hash_ff + {24'd0, req_payload.name_byte};
         end
      end
   end

   // Result register contents and its valid flag.
   always_comb begin
      rsp_in.symbol_hash      = hash_ff;
      rsp_in.bucket_number    = hash_ff[BUCKET_W-1:0];
      rsp_in.is_local         = local_sym;
      rsp_in.bloom_word_index = word_idx;
      rsp_in.bloom_word_value = word_new;
      if (accept && terminator) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= HASH_SEED;
         shift_ff     <= BLOOM_SHIFT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            shift_ff <= csr_data;
         end
      end
   end

   // The payload register loads only with a new result.
   always_ff @(posedge clock) begin
      if (accept && terminator) begin
         rsp_ff <= rsp_in;
      end
   end

   // Bloom words, cleared at reset and updated once per terminator.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BLOOM_WORDS; i++) begin
            bloom_ff[i] <= '0;
         end
      end else if (accept && terminator) begin
         bloom_ff[word_idx] <= word_new;
      end
   end

`ifndef ASSERT_OFF
   // A terminator always yields a pending result in the next cycle.
   a_term_result: assert property (@(posedge clock) disable iff (reset)
      (accept && terminator) |=> rsp_valid)
      else $error("terminator did not produce a result");

   // The hash restarts from the seed after each completed name.
   a_hash_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && terminator) |=> (hash_ff == HASH_SEED))
      else $error("running hash not reseeded");

   // The reported word always holds the bit chosen by the hash itself.
   a_bloom_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.bloom_word_value[rsp_payload.symbol_hash[4:0]])
      else $error("bloom bit missing from reported word");

   // A name byte on its own never creates a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && accept && !terminator) |=> !rsp_valid)
      else $error("result raised without a terminator");
`endif

endmodule
